// ===== sv/ebp_pkg.sv =====
package ebp_pkg;

  // Operation codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_BLEND  = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_PASS   = 2'd3
  } func_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_WEIGHT_SLOPE   = 2'd2;
  localparam logic [1:0] REG_OUTPUT_SHIFT   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [15:0] LOW_THRESHOLD_RESET  = 16'd45875;
  localparam logic [15:0] HIGH_THRESHOLD_RESET = 16'd52429;
  localparam logic [15:0] WEIGHT_SLOPE_RESET   = 16'd40960;
  localparam logic [3:0]  OUTPUT_SHIFT_RESET   = 4'd0;

  // Q0.16 full scale and weight of one.
  localparam logic [15:0] ACC_MAX  = 16'hFFFF;
  localparam logic [16:0] Q16_ONE  = 17'h10000;

  // Live configuration as seen by the datapath.
  typedef struct packed {
    logic [15:0] low_threshold;
    logic [15:0] high_threshold;
    logic [15:0] weight_slope;
    logic [3:0]  output_shift;
  } cfg_t;

endpackage

// ===== sv/exposure_blend_pixel.sv =====
// Exposure blend for one colour sample of a bracketed exposure stack.
// Input channel (in_valid/in_ready) carries func, sample, acc_value and
// layer_gain; func selects first-layer load, blend, finish scaling or pass.
// Output channel (out_valid/out_ready) returns one transaction per input:
// out_value (Q0.16 accumulator, or Q16.16 after finish) and saturated.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// the thresholds, the weight slope and the output shift; it is always ready
// and should be used only while the pipeline is empty.
// One transaction is accepted every cycle while the output is not stalled.
// The pipeline has five register stages: normalize, two 16x16 multiplies,
// weight clamp, two 16x17 blend multiplies, and the rounded sum in the
// output register.
// Synchronous reset empties the pipeline and loads the default thresholds,
// slope and shift. When the receiver holds out_ready low with a result
// waiting, the whole pipeline holds and in_ready drops; no transaction is
// lost or repeated.
module exposure_blend_pixel (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  sample,
  input  logic [15:0] acc_value,
  input  logic [15:0] layer_gain,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic        saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ebp_pkg::*;

  cfg_t cfg;
  logic advance;

  // The pipeline moves unless a finished result is waiting on the receiver.
  assign advance  = ~out_valid | out_ready;
  assign in_ready = advance;

  ebp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ebp_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (in_valid),
    .func       (func),
    .sample     (sample),
    .acc_value  (acc_value),
    .layer_gain (layer_gain),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .saturated  (saturated)
  );

endmodule

// ===== sv/ebp_cfg_regs.sv =====
module ebp_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output ebp_pkg::cfg_t     cfg
);
  import ebp_pkg::*;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register file with reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold  <= LOW_THRESHOLD_RESET;
      cfg.high_threshold <= HIGH_THRESHOLD_RESET;
      cfg.weight_slope   <= WEIGHT_SLOPE_RESET;
      cfg.output_shift   <= OUTPUT_SHIFT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOW_THRESHOLD:  cfg.low_threshold  <= cfg_data;
        REG_HIGH_THRESHOLD: cfg.high_threshold <= cfg_data;
        REG_WEIGHT_SLOPE:   cfg.weight_slope   <= cfg_data;
        REG_OUTPUT_SHIFT:   cfg.output_shift   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/ebp_pipe.sv =====
module ebp_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  logic [1:0]        func,
  input  logic [7:0]        sample,
  input  logic [15:0]       acc_value,
  input  logic [15:0]       layer_gain,
  input  ebp_pkg::cfg_t     cfg,
  output logic              out_valid,
  output logic [31:0]       out_value,
  output logic              saturated
);
  import ebp_pkg::*;

  // Stage valid bits; stage 5 is the output register.
  logic [4:0] valid;

  // Stage 1: normalized sample and finish value.
  func_t       s1_func;
  logic [15:0] s1_acc;
  logic [15:0] s1_gain;
  logic [15:0] s1_norm;
  logic [31:0] s1_fin;
  logic        s1_fsat;
  // Stage 2: raw products.
  func_t       s2_func;
  logic [15:0] s2_acc;
  logic [15:0] s2_norm;
  logic [31:0] s2_fin;
  logic        s2_fsat;
  logic [31:0] s2_wprod;
  logic [31:0] s2_lprod;
  logic        s2_ge_high;
  logic        s2_lt_low;
  // Stage 3: weight and scaled layer.
  func_t       s3_func;
  logic [15:0] s3_acc;
  logic [15:0] s3_norm;
  logic [31:0] s3_fin;
  logic        s3_fsat;
  logic [16:0] s3_weight;
  logic [15:0] s3_layer;
  // Stage 4: blend products.
  func_t       s4_func;
  logic [15:0] s4_acc;
  logic [15:0] s4_norm;
  logic [31:0] s4_fin;
  logic        s4_fsat;
  logic [32:0] s4_pacc;
  logic [32:0] s4_player;

  // Combinational helpers.
  logic [16:0] norm_full;
  logic [15:0] norm;
  logic [46:0] shifted;
  logic [15:0] diff;
  logic [32:0] wround;
  logic [20:0] wscaled;
  logic [16:0] weight;
  logic [32:0] lround;
  logic [16:0] inv_weight;
  logic [33:0] bsum;
  logic [17:0] bscaled;
  logic [15:0] blend;

  // sample*65536/255 rounded equals 257*sample plus one for the upper half.
  assign norm_full = 17'(sample) * 17'd257 + 17'(sample[7]);
  assign norm      = norm_full[16] ? ACC_MAX : norm_full[15:0];
  assign shifted   = 47'(acc_value) << cfg.output_shift;

  // Distance below the high threshold, used only when norm is below it.
  assign diff = cfg.high_threshold - s1_norm;

  // Weight rounding and clamp; the high test takes priority.
  assign wround  = 33'(s2_wprod) + 33'd2048;
  assign wscaled = wround[32:12];
  always_comb begin
    if (s2_ge_high) begin
      weight = 17'd0;
    end else if (s2_lt_low) begin
      weight = Q16_ONE;
    end else if (wscaled > 21'(Q16_ONE)) begin
      weight = Q16_ONE;
    end else begin
      weight = wscaled[16:0];
    end
  end
  assign lround = 33'(s2_lprod) + 33'd32768;

  assign inv_weight = Q16_ONE - s3_weight;

  // Final blend rounding and clamp.
  assign bsum    = 34'(s4_pacc) + 34'(s4_player) + 34'd32768;
  assign bscaled = bsum[33:16];
  assign blend   = (bscaled > 18'(ACC_MAX)) ? ACC_MAX : bscaled[15:0];

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (advance) begin
      valid <= {valid[3:0], in_valid};
    end
  end
  assign out_valid = valid[4];

  // Payload registers.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_func    <= func_t'(func);
      s1_acc     <= acc_value;
      s1_gain    <= layer_gain;
      s1_norm    <= norm;
      s1_fin     <= shifted[31:0];
      s1_fsat    <= |shifted[46:32];

      s2_func    <= s1_func;
      s2_acc     <= s1_acc;
      s2_norm    <= s1_norm;
      s2_fin     <= s1_fin;
      s2_fsat    <= s1_fsat;
      s2_wprod   <= 32'(diff) * 32'(cfg.weight_slope);
      s2_lprod   <= 32'(s1_norm) * 32'(s1_gain);
      s2_ge_high <= s1_norm >= cfg.high_threshold;
      s2_lt_low  <= s1_norm < cfg.low_threshold;

      s3_func    <= s2_func;
      s3_acc     <= s2_acc;
      s3_norm    <= s2_norm;
      s3_fin     <= s2_fin;
      s3_fsat    <= s2_fsat;
      s3_weight  <= weight;
      s3_layer   <= lround[31:16];

      s4_func    <= s3_func;
      s4_acc     <= s3_acc;
      s4_norm    <= s3_norm;
      s4_fin     <= s3_fin;
      s4_fsat    <= s3_fsat;
      s4_pacc    <= 33'(s3_acc) * 33'(inv_weight);
      s4_player  <= 33'(s3_layer) * 33'(s3_weight);

      case (s4_func)
        FUNC_LOAD: begin
          out_value <= 32'(s4_norm);
          saturated <= 1'b0;
        end
        FUNC_BLEND: begin
          out_value <= 32'(blend);
          saturated <= 1'b0;
        end
        FUNC_FINISH: begin
          out_value <= s4_fsat ? 32'hFFFF_FFFF : s4_fin;
          saturated <= s4_fsat;
        end
        default: begin
          out_value <= 32'(s4_acc);
          saturated <= 1'b0;
        end
      endcase
    end
  end

endmodule
